// File: src/fbpa_pkg.sv
// fbpa_pkg: shared types and constants of the fixed block pool allocator
// no dependencies; imported by the interfaces and every module of the block
`default_nettype none

package fbpa_pkg;

  // field widths of the channels
  localparam int CMD_W      = 2;
  localparam int IDX_IN_W   = 8;
  localparam int GUARD_W    = 16;
  localparam int STATUS_W   = 2;
  localparam int OFF_W      = 20;
  localparam int USED_W     = 9;
  localparam int BS_W       = 13;
  localparam int TB_W       = 9;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // request commands
  localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE_ALL = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_GUARD = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = 8'd1;

  localparam logic [BS_W-1:0] BLOCK_SIZE_RST   = 13'd4;
  localparam logic [TB_W-1:0] TOTAL_BLOCKS_RST = 9'd256;

  localparam logic [GUARD_W-1:0] GUARD_WORD = 16'hBEEF;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic execute;  // update pool state and result registers
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// File: src/fbpa_ifs.sv
// fbpa channel interfaces: request, result and configuration write channels
// depends on fbpa_pkg for field widths
`default_nettype none

interface fbpa_req_if import fbpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [IDX_IN_W-1:0] block_index;
  logic [GUARD_W-1:0]  guard_seen;

  modport source (output valid, command, block_index, guard_seen, input ready);
  modport sink   (input valid, command, block_index, guard_seen, output ready);
endinterface

interface fbpa_rsp_if import fbpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_IN_W-1:0] granted_index;
  logic [OFF_W-1:0]    byte_offset;
  logic [GUARD_W-1:0]  guard_to_write;
  logic [USED_W-1:0]   used_count;

  modport source (output valid, status, granted_index, byte_offset, guard_to_write,
                  used_count, input ready);
  modport sink   (input valid, status, granted_index, byte_offset, guard_to_write,
                  used_count, output ready);
endinterface

interface fbpa_cfg_if import fbpa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/fbpa_ctrl.sv
// fbpa_ctrl: request sequencer of the allocator (capture, execute, deliver)
// depends on fbpa_pkg for the command struct
`default_nettype none

module fbpa_ctrl import fbpa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output ctrl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.execute = (state_r == S_EXEC);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.execute)
    else $error("captured request not executed next cycle");

  a_exec_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> (out_valid && !in_ready))
    else $error("executed request did not present a result");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && (out_valid || cmd.execute)))
    else $error("new request taken while one is in flight");
`endif

endmodule

`default_nettype wire

// File: src/fbpa_dp.sv
// fbpa_dp: allocator datapath with config registers, free list link memory,
// stack head, fresh pointer, use count and result registers; uses fbpa_pkg
`default_nettype none

module fbpa_dp import fbpa_pkg::*; #(
  parameter int MAX_BLOCKS = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctrl_cmd_t             cmd,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [CMD_W-1:0]      in_command,
  input  wire logic [IDX_IN_W-1:0]   in_block_index,
  input  wire logic [GUARD_W-1:0]    in_guard_seen,
  output logic [STATUS_W-1:0]        out_status,
  output logic [IDX_IN_W-1:0]        out_granted_index,
  output logic [OFF_W-1:0]           out_byte_offset,
  output logic [GUARD_W-1:0]         out_guard_to_write,
  output logic [USED_W-1:0]          out_used_count
);

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int PTR_W  = IDX_W + 1;
  localparam int CMP_W  = (PTR_W > TB_W) ? PTR_W : TB_W;
  localparam int PROD_W = IDX_W + BS_W + 1;
  localparam int OFFX_W = (PROD_W > OFF_W) ? PROD_W : OFF_W;
  localparam logic [PTR_W-1:0] MARK = PTR_W'(MAX_BLOCKS);

  // configuration
  logic [BS_W-1:0] block_size_r;
  logic [TB_W-1:0] total_blocks_r;

  // latched request
  logic [CMD_W-1:0]    cmd_r;
  logic [IDX_IN_W-1:0] idx_r;
  logic [GUARD_W-1:0]  guard_r;

  // pool state
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] fresh_r, fresh_nxt;
  logic [PTR_W-1:0] used_r, used_nxt;

  // link memory
  logic [PTR_W-1:0] link_mem [MAX_BLOCKS];
  logic [PTR_W-1:0] link_rd_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             link_we;

  // result registers
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [IDX_W-1:0]    grant_r, grant_nxt;
  logic [OFF_W-1:0]    offset_r, offset_nxt;
  logic [GUARD_W-1:0]  gout_r, gout_nxt;

  logic [CMP_W-1:0]  pool_ext, tb_ext, fresh_ext, idx_ext, used_ext, grant_ext;
  logic [PTR_W-1:0]  link_clamped;
  logic              head_avail;
  logic              got;
  logic [BS_W:0]     bs_plus2;
  logic [PROD_W-1:0] prod;
  logic [OFFX_W-1:0] prod_ext;

  assign tb_ext    = CMP_W'(total_blocks_r);
  assign pool_ext  = (tb_ext > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : tb_ext;
  assign fresh_ext = CMP_W'(fresh_r);
  assign idx_ext   = CMP_W'(idx_r);
  assign used_ext  = CMP_W'(used_r);
  assign grant_ext = CMP_W'(grant_r);

  assign head_avail   = (head_r < MARK);
  assign link_clamped = (link_rd_r > MARK) ? MARK : link_rd_r;
  assign rd_addr      = head_avail ? head_r[IDX_W-1:0] : '0;
  assign wr_addr      = idx_ext[IDX_W-1:0];

  always_comb begin
    head_nxt   = head_r;
    fresh_nxt  = fresh_r;
    used_nxt   = used_r;
    status_nxt = ST_OK;
    grant_nxt  = '0;
    gout_nxt   = '0;
    link_we    = 1'b0;
    got        = 1'b0;
    case (cmd_r)
      CMD_ALLOC: begin
        // recycled blocks first, then the lowest never-used one
        if (head_avail) begin
          grant_nxt = head_r[IDX_W-1:0];
          head_nxt  = link_clamped;
          got       = 1'b1;
        end else if (fresh_ext < pool_ext) begin
          grant_nxt = fresh_r[IDX_W-1:0];
          fresh_nxt = fresh_r + PTR_W'(1);
          got       = 1'b1;
        end
        if (got) begin
          if (used_r < MARK) used_nxt = used_r + PTR_W'(1);
          gout_nxt = GUARD_WORD;
        end else begin
          status_nxt = ST_EMPTY;
        end
      end
      CMD_FREE: begin
        if (idx_ext >= pool_ext) begin
          status_nxt = ST_RANGE;
        end else begin
          // block is freed even with a broken guard
          if (guard_r != GUARD_WORD) status_nxt = ST_GUARD;
          link_we  = 1'b1;
          head_nxt = idx_ext[PTR_W-1:0];
          if (used_r != '0) used_nxt = used_r - PTR_W'(1);
        end
      end
      CMD_FREE_ALL: begin
        head_nxt  = MARK;
        fresh_nxt = '0;
        used_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  assign bs_plus2   = {1'b0, block_size_r} + (BS_W + 1)'(2);
  assign prod       = PROD_W'(grant_nxt) * PROD_W'(bs_plus2);
  assign prod_ext   = OFFX_W'(prod);
  assign offset_nxt = prod_ext[OFF_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r   <= BLOCK_SIZE_RST;
      total_blocks_r <= TOTAL_BLOCKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_SIZE:   block_size_r   <= cfg_data[BS_W-1:0];
        REG_TOTAL_BLOCKS: total_blocks_r <= cfg_data[TB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_command;
      idx_r   <= in_block_index;
      guard_r <= in_guard_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= MARK;
      fresh_r  <= '0;
      used_r   <= '0;
      status_r <= ST_OK;
      grant_r  <= '0;
      offset_r <= '0;
      gout_r   <= '0;
    end else if (cmd.execute) begin
      head_r   <= head_nxt;
      fresh_r  <= fresh_nxt;
      used_r   <= used_nxt;
      status_r <= status_nxt;
      grant_r  <= grant_nxt;
      offset_r <= offset_nxt;
      gout_r   <= gout_nxt;
    end
  end

  // link under the stack head is read every cycle; head only moves on execute
  always_ff @(posedge clk) begin
    if (cmd.execute && link_we) begin
      link_mem[wr_addr] <= head_r;
    end
    link_rd_r <= link_mem[rd_addr];
  end

  assign out_status         = status_r;
  assign out_granted_index  = grant_ext[IDX_IN_W-1:0];
  assign out_byte_offset    = offset_r;
  assign out_guard_to_write = gout_r;
  assign out_used_count     = used_ext[USED_W-1:0];

`ifndef SYNTHESIS
  a_head_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= MARK)
    else $error("stack head beyond empty marker");

  a_fresh_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= MARK)
    else $error("fresh pointer beyond pool");

  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= MARK)
    else $error("use count beyond pool");

  a_guard_only_on_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (gout_r == GUARD_WORD) |-> (status_r == ST_OK))
    else $error("guard word issued with failing status");

  a_free_all_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.execute && cmd_r == CMD_FREE_ALL) |=> (used_r == '0 && head_r == MARK))
    else $error("free all left pool state behind");
`endif

endmodule

`default_nettype wire

// File: src/fixed_block_pool_allocator_top.sv
// fixed_block_pool_allocator_top: block pool allocator top level
// depends on fbpa_pkg, fbpa_ifs, fbpa_ctrl and fbpa_dp
//
//   channel   dir  handshake     payload
//   in_if     in   valid/ready   command, block_index, guard_seen
//   out_if    out  valid/ready   status, granted_index, byte_offset,
//                                guard_to_write, used_count
//   cfg_if    in   valid/ready   index, data (0 block_size, 1 total_blocks)
//
// the accept edge latches a request, the next edge updates the pool state and
// result registers from the link word already read under the stack head, and the
// result is offered once those registers are written; one request is in flight and
// the next request is taken the cycle after the result is taken
// reset (rst_n low, synchronous) empties the pool and restores the config
// a stalled result holds the block; config writes are always accepted
`default_nettype none

module fixed_block_pool_allocator_top import fbpa_pkg::*; #(
  parameter int MAX_BLOCKS = 256
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fbpa_req_if.sink    in_if,
  fbpa_rsp_if.source  out_if,
  fbpa_cfg_if.sink    cfg_if
);

  ctrl_cmd_t cmd;

  assign cfg_if.ready = 1'b1;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  fbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_we             (cfg_if.valid),
    .cfg_index          (cfg_if.index),
    .cfg_data           (cfg_if.data),
    .in_command         (in_if.command),
    .in_block_index     (in_if.block_index),
    .in_guard_seen      (in_if.guard_seen),
    .out_status         (out_if.status),
    .out_granted_index  (out_if.granted_index),
    .out_byte_offset    (out_if.byte_offset),
    .out_guard_to_write (out_if.guard_to_write),
    .out_used_count     (out_if.used_count)
  );

endmodule

`default_nettype wire
